FILE: rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue engine.
package stq_pkg;

   // Command codes on the request side
   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_ARM     = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;
   localparam logic [1:0] MODE_TICK    = 2'd3;

   // Status codes on the response side
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFREE = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;
   localparam logic [1:0] ST_IDLE   = 2'd3;

   // Fixed field widths of the ports
   localparam int MODE_W = 2;
   localparam int SLOT_W = 7;
   localparam int TIME_W = 64;

   // Operation broadcast to every cell of the pending chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_RANK,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  ivl;
   } cell_cmd_type;

endpackage

FILE: rtl/stq_ram.sv
// Generic single-port-write, registered-read RAM.
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/stq_cell.sv
// One position of the pending order: holds an entry and shifts with its neighbors.
module stq_cell import stq_pkg::*; #(
   parameter int SW = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic [SW-1:0]     key_slot,
   input  logic              left_valid,
   input  logic [SW-1:0]     left_slot,
   input  logic [TIME_W-1:0] left_start,
   input  logic [TIME_W-1:0] left_period,
   input  logic              right_valid,
   input  logic [SW-1:0]     right_slot,
   input  logic [TIME_W-1:0] right_start,
   input  logic [TIME_W-1:0] right_period,
   input  logic              rmark_in,
   input  logic              imark_in,
   output logic              rmark_out,
   output logic              imark_out,
   output logic              cell_valid,
   output logic [SW-1:0]     cell_slot,
   output logic [TIME_W-1:0] cell_start,
   output logic [TIME_W-1:0] cell_period
);

   logic              valid_ff;
   logic [SW-1:0]     slot_ff;
   logic [TIME_W-1:0] start_ff;
   logic [TIME_W-1:0] period_ff;
   logic [TIME_W:0]   rem_ff;
   logic              match;
   logic              later;

   // remove marks the matching cell and all after it
   assign match     = valid_ff && (slot_ff == key_slot);
   assign rmark_out = rmark_in || match;

   // insert point: first cell that is empty or has strictly more time left
   assign later     = !valid_ff || (!rem_ff[TIME_W] && (rem_ff[TIME_W-1:0] > cmd.ivl));
   assign imark_out = imark_in || later;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            CELL_REMOVE: begin
               // shift left over the removed entry
               if (rmark_out) begin
                  valid_ff  <= right_valid;
                  slot_ff   <= right_slot;
                  start_ff  <= right_start;
                  period_ff <= right_period;
               end
            end
            CELL_RANK: begin
               // remaining time, borrow bit flags entries whose elapsed time exceeds the period
               rem_ff <= {1'b0, period_ff} - {1'b0, cmd.now - start_ff};
            end
            CELL_INSERT: begin
               if (imark_in) begin
                  valid_ff  <= left_valid;
                  slot_ff   <= left_slot;
                  start_ff  <= left_start;
                  period_ff <= left_period;
               end else if (later) begin
                  valid_ff  <= 1'b1;
                  slot_ff   <= key_slot;
                  start_ff  <= cmd.now;
                  period_ff <= cmd.ivl;
               end
            end
            default: begin
               valid_ff <= valid_ff;
            end
         endcase
      end
   end

   assign cell_valid  = valid_ff;
   assign cell_slot   = slot_ff;
   assign cell_start  = start_ff;
   assign cell_period = period_ff;

endmodule

FILE: rtl/sorted_timer_queue_engine_core.sv
// Top level of the sorted timer queue engine: command sequencer, slot pool and pending chain.
//
// Each request word carries one command and yields exactly one response word. A command passes
// through an execute step and then, by kind, straight to the response hand-over (release, idle
// ticks and rejected commands), to an allocate step (free list read), to a tag step for a fired
// tick (tag memory read), or for arm, after the remove in the execute step, to the rank and
// insert steps through the chain of SLOTS cells. A stalled output holds the hand-over back
// once a second response is ready. One command is processed at a time; a new request
// word is taken while the previous response word still waits on a stalled output. Pending
// timers sit in the cell chain sorted by remaining time; only the head is checked on a tick.
module sorted_timer_queue_engine_core import stq_pkg::*; #(
   parameter int SLOTS    = 128,
   parameter int TAG_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TIME_W-1:0]   req_interval,
   input  logic [TAG_BITS-1:0] req_tag,
   input  logic [TIME_W-1:0]   req_now,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic [TAG_BITS-1:0] rsp_tag_out
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_ALLOC, S_RANK, S_INSERT, S_TAG, S_DONE
   } state_type;

   state_type           state_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [TIME_W-1:0]   ivl_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [SLOTS-1:0]    in_use_ff;
   logic [SLOTS-1:0]    armed_ff;
   logic [SLOTS-1:0]    fv_ff;
   logic [SW-1:0]       head_ff;
   logic [SW-1:0]       tail_ff;
   logic [CW-1:0]       free_count_ff;
   logic [1:0]          res_status_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic [TAG_BITS-1:0] res_tag_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;

   logic                c_valid  [SLOTS+1];
   logic [SW-1:0]       c_slot   [SLOTS+1];
   logic [TIME_W-1:0]   c_start  [SLOTS+1];
   logic [TIME_W-1:0]   c_period [SLOTS+1];
   logic                rmark    [SLOTS+1];
   logic                imark    [SLOTS+1];
   logic [SLOTS-1:0]    valid_vec;

   cell_cmd_type        cmd;
   logic [SW-1:0]       key_slot;
   logic [SW-1:0]       sidx;
   logic                bad;
   logic                due;
   logic                fifo_we;
   logic [SW-1:0]       fifo_rd;
   logic [SW-1:0]       alloc_slot;
   logic                tag_we;
   logic [TAG_BITS-1:0] tag_rd;
   logic                accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // decode of the held command
   assign sidx = SW'(slot_ff);
   assign bad  = (32'(slot_ff) >= SLOTS) || !in_use_ff[sidx];
   assign due  = c_valid[0] && ((now_ff - c_start[0]) >= c_period[0]);
   assign alloc_slot = fv_ff[head_ff] ? fifo_rd : (SW'(SLOTS - 1) - head_ff);

   // broadcast command to the cell chain
   always_comb begin
      cmd.op   = CELL_HOLD;
      cmd.now  = now_ff;
      cmd.ivl  = ivl_ff;
      key_slot = sidx;
      case (state_ff)
         S_EXEC: begin
            if ((mode_ff == MODE_ARM || mode_ff == MODE_RELEASE) && !bad && armed_ff[sidx]) begin
               cmd.op = CELL_REMOVE;
            end else if (mode_ff == MODE_TICK && due) begin
               cmd.op   = CELL_REMOVE;
               key_slot = c_slot[0];
            end
         end
         S_RANK:   cmd.op = CELL_RANK;
         S_INSERT: cmd.op = CELL_INSERT;
         default:  cmd.op = CELL_HOLD;
      endcase
   end

   // chain of cells, entry 0 is the head
   assign rmark[0]         = 1'b0;
   assign imark[0]         = 1'b0;
   assign c_valid[SLOTS]   = 1'b0;
   assign c_slot[SLOTS]    = '0;
   assign c_start[SLOTS]   = '0;
   assign c_period[SLOTS]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic              lv;
      logic [SW-1:0]     ls;
      logic [TIME_W-1:0] lt;
      logic [TIME_W-1:0] lp;
      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign ls = '0;
         assign lt = '0;
         assign lp = '0;
      end else begin : g_rest
         assign lv = c_valid[i-1];
         assign ls = c_slot[i-1];
         assign lt = c_start[i-1];
         assign lp = c_period[i-1];
      end
      stq_cell #(.SW(SW)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .key_slot     (key_slot),
         .left_valid   (lv),
         .left_slot    (ls),
         .left_start   (lt),
         .left_period  (lp),
         .right_valid  (c_valid[i+1]),
         .right_slot   (c_slot[i+1]),
         .right_start  (c_start[i+1]),
         .right_period (c_period[i+1]),
         .rmark_in     (rmark[i]),
         .imark_in     (imark[i]),
         .rmark_out    (rmark[i+1]),
         .imark_out    (imark[i+1]),
         .cell_valid   (c_valid[i]),
         .cell_slot    (c_slot[i]),
         .cell_start   (c_start[i]),
         .cell_period  (c_period[i])
      );
   end

   // gather the cell valid bits into one vector
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         valid_vec[k] = c_valid[k];
      end
   end

   // free slot FIFO storage
   assign fifo_we = (state_ff == S_EXEC) && (mode_ff == MODE_RELEASE) && !bad
                    && (free_count_ff < CW'(SLOTS));

   stq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (sidx),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   // user tag storage, read at the pending head
   assign tag_we = (state_ff == S_ALLOC);

   stq_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (alloc_slot),
      .wr_data (tag_ff),
      .rd_addr (c_slot[0]),
      .rd_data (tag_rd)
   );

   // sequencer, slot flags and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_use_ff     <= '0;
         armed_ff      <= '0;
         fv_ff         <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_count_ff <= CW'(SLOTS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_mode;
                  slot_ff  <= req_slot;
                  ivl_ff   <= req_interval;
                  tag_ff   <= req_tag;
                  now_ff   <= req_now;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_tag_ff <= '0;
               case (mode_ff)
                  MODE_ALLOC: begin
                     res_slot_ff <= '0;
                     if (free_count_ff == '0) begin
                        res_status_ff <= ST_NOFREE;
                        state_ff      <= S_DONE;
                     end else begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_ALLOC;
                     end
                  end
                  MODE_ARM: begin
                     res_slot_ff <= slot_ff;
                     if (bad) begin
                        res_status_ff <= ST_BAD;
                        state_ff      <= S_DONE;
                     end else begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_RANK;
                     end
                  end
                  MODE_RELEASE: begin
                     res_slot_ff <= slot_ff;
                     state_ff    <= S_DONE;
                     if (bad) begin
                        res_status_ff <= ST_BAD;
                     end else begin
                        res_status_ff   <= ST_OK;
                        armed_ff[sidx]  <= 1'b0;
                        in_use_ff[sidx] <= 1'b0;
                        if (fifo_we) begin
                           fv_ff[tail_ff] <= 1'b1;
                           tail_ff <= (tail_ff == SW'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
                           free_count_ff <= free_count_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (due) begin
                        armed_ff[c_slot[0]] <= 1'b0;
                        res_status_ff <= ST_OK;
                        res_slot_ff   <= SLOT_W'(c_slot[0]);
                        state_ff      <= S_TAG;
                     end else begin
                        res_status_ff <= ST_IDLE;
                        res_slot_ff   <= '0;
                        state_ff      <= S_DONE;
                     end
                  end
               endcase
            end
            S_ALLOC: begin
               in_use_ff[alloc_slot] <= 1'b1;
               armed_ff[alloc_slot]  <= 1'b0;
               head_ff       <= (head_ff == SW'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
               free_count_ff <= free_count_ff - 1'b1;
               res_slot_ff   <= SLOT_W'(alloc_slot);
               state_ff      <= S_DONE;
            end
            S_RANK: begin
               state_ff <= S_INSERT;
            end
            S_INSERT: begin
               armed_ff[sidx] <= 1'b1;
               state_ff       <= S_DONE;
            end
            S_TAG: begin
               res_tag_ff <= tag_rd;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_tag_ff    <= res_tag_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_tag_out  = rsp_tag_ff;

   // the head cell of the chain is filled whenever the second cell is
   a_packed: assert property (@(posedge clock) disable iff (reset)
      c_valid[1] |-> c_valid[0])
      else $error("pending chain has a gap at the head");

   // number of armed flags matches the number of filled cells between commands
   a_armed_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(armed_ff) == $countones(valid_vec)))
      else $error("armed flags disagree with pending chain");

   // free count never exceeds the pool
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CW'(SLOTS))
      else $error("free count above pool size");

endmodule

FILE: test/tb_sorted_timer_queue_engine_core.sv
// Testbench for the sorted timer queue engine: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_sorted_timer_queue_engine_core;
   import stq_pkg::*;

   localparam int NUM_SLOTS  = 128;
   localparam int WDOG_LIMIT = 5000;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  slot;
      logic [31:0] tag;
   } result_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [1:0]   req_mode = MODE_TICK;
   logic [6:0]   req_slot = '0;
   logic [63:0]  req_interval = '0;
   logic [31:0]  req_tag = '0;
   logic [63:0]  req_now = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [1:0]   rsp_status;
   logic [6:0]   rsp_slot_out;
   logic [31:0]  rsp_tag_out;

   // Predictor state
   bit           slot_alloc [NUM_SLOTS];
   bit           slot_armed [NUM_SLOTS];
   logic [63:0]  slot_start [NUM_SLOTS];
   logic [63:0]  slot_period [NUM_SLOTS];
   logic [31:0]  slot_tag [NUM_SLOTS];
   logic [6:0]   timer_order [$];
   logic [6:0]   free_slots [$];
   result_word_type pending_results [$];

   int           fail_count = 0;
   int           idle_cycles = 0;
   int           long_hold = 0;
   bit           quiet = 1'b0;
   logic [63:0]  clock_us = 64'd1000;

   sorted_timer_queue_engine_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Drop a slot from the timer order
   function automatic void order_remove(logic [6:0] s);
      foreach (timer_order[i]) begin
         if (timer_order[i] == s) begin
            timer_order.delete(i);
            return;
         end
      end
   endfunction

   // Compute the response for one accepted command word and update state
   function automatic result_word_type timer_response(logic [1:0] mode, logic [6:0] slot,
                                                      logic [63:0] ivl, logic [31:0] tag,
                                                      logic [63:0] now);
      result_word_type r;
      logic [6:0]   s;
      logic [63:0]  el;
      int           pos;
      r = '{status: ST_OK, slot: '0, tag: '0};
      case (mode)
         MODE_ALLOC: begin
            if (free_slots.size() == 0) begin
               r.status = ST_NOFREE;
            end else begin
               s = free_slots.pop_front();
               slot_alloc[s] = 1'b1;
               slot_armed[s] = 1'b0;
               slot_tag[s] = tag;
               r.slot = s;
            end
         end
         MODE_ARM, MODE_RELEASE: begin
            r.slot = slot;
            if (!slot_alloc[slot]) begin
               r.status = ST_BAD;
            end else if (mode == MODE_ARM) begin
               if (slot_armed[slot]) order_remove(slot);
               slot_start[slot] = now;
               slot_period[slot] = ivl;
               pos = timer_order.size();
               foreach (timer_order[i]) begin
                  el = now - slot_start[timer_order[i]];
                  if (slot_period[timer_order[i]] > el &&
                      slot_period[timer_order[i]] - el > ivl) begin
                     pos = i;
                     break;
                  end
               end
               timer_order.insert(pos, slot);
               slot_armed[slot] = 1'b1;
            end else begin
               if (slot_armed[slot]) order_remove(slot);
               slot_armed[slot] = 1'b0;
               slot_alloc[slot] = 1'b0;
               free_slots.push_back(slot);
            end
         end
         default: begin
            r.status = ST_IDLE;
            if (timer_order.size() > 0) begin
               s = timer_order[0];
               if (now - slot_start[s] >= slot_period[s]) begin
                  void'(timer_order.pop_front());
                  slot_armed[s] = 1'b0;
                  r = '{status: ST_OK, slot: s, tag: slot_tag[s]};
               end
            end
         end
      endcase
      return r;
   endfunction

   // Offer one command word after a random gap (none when quiet) and wait until it is taken
   task automatic send_word(logic [1:0] mode, logic [6:0] slot, logic [63:0] ivl,
                            logic [31:0] tag, logic [63:0] now);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_slot <= slot;
      req_interval <= ivl;
      req_tag <= tag;
      req_now <= now;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(timer_response(mode, slot, ivl, tag, now));
   endtask

   // Check each response word and draw the stall before the next one
   initial begin
      int           hold;
      result_word_type exp_r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) long_hold--;
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected word status=%0d slot=%0d tag=%h", $time,
                        rsp_status, rsp_slot_out, rsp_tag_out);
               fail_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_r.status, rsp_status);
                  fail_count++;
               end
               if (rsp_slot_out !== exp_r.slot) begin
                  $display("%0t: slot expected %0d actual %0d", $time,
                           exp_r.slot, rsp_slot_out);
                  fail_count++;
               end
               if (rsp_tag_out !== exp_r.tag) begin
                  $display("%0t: tag expected %h actual %h", $time, exp_r.tag, rsp_tag_out);
                  fail_count++;
               end
            end
            hold = quiet ? 0 : $urandom_range(0, 17);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0) || (long_hold > 0);
      end
   end

   // Watch for cycles with no progress on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [6:0] pick_live_slot();
      logic [6:0] s;
      repeat (8) begin
         s = 7'($urandom_range(0, NUM_SLOTS - 1));
         if (slot_alloc[s]) return s;
      end
      return s;
   endfunction

   // Directed corners: empty tick, tag extremes, bad slots, ordering, wrap of time
   task automatic test_directed();
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd0);
      send_word(MODE_ALLOC, 7'd0, 64'd0, 32'hFFFF_FFFF, 64'd0);
      send_word(MODE_ALLOC, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 64'd0);
      send_word(MODE_ALLOC, 7'd0, 64'd0, 32'h5A5A_A5A5, 64'd0);
      send_word(MODE_ARM, 7'd0, 64'd10, 32'd0, 64'd100);
      send_word(MODE_RELEASE, 7'd1, 64'd0, 32'd0, 64'd0);
      send_word(MODE_ARM, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'd100);
      send_word(MODE_ARM, 7'd126, 64'd0, 32'd0, 64'd100);
      send_word(MODE_ARM, 7'd125, 64'd50, 32'd0, 64'd100);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd100);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd120);
      send_word(MODE_ARM, 7'd125, 64'd5, 32'd0, 64'd120);
      send_word(MODE_ARM, 7'd126, 64'd5, 32'd0, 64'd120);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd124);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd125);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd125);
      send_word(MODE_ARM, 7'd125, 64'd8, 32'd0, 64'hFFFF_FFFF_FFFF_FFFC);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd3);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd4);
      send_word(MODE_RELEASE, 7'd127, 64'd0, 32'd0, 64'd0);
      send_word(MODE_RELEASE, 7'd127, 64'd0, 32'd0, 64'd0);
      send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, 64'd5);
   endtask

   // Drain the free list, overflow it, then give every third slot back
   task automatic test_exhaust();
      while (free_slots.size() > 0)
         send_word(MODE_ALLOC, 7'd0, 64'd0, $urandom(), clock_us);
      send_word(MODE_ALLOC, 7'd0, 64'd0, $urandom(), clock_us);
      for (int s = 0; s < NUM_SLOTS; s += 3)
         send_word(MODE_RELEASE, s[6:0], 64'd0, 32'd0, clock_us);
   endtask

   // Random command mix with an advancing clock and occasional jumps
   task automatic test_random(int count);
      int         pick;
      logic [63:0] ivl;
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
         clock_us += 64'($urandom_range(0, 40));
         if ($urandom_range(0, 99) == 0) clock_us = rand64();
         ivl = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 150));
         pick = $urandom_range(0, 99);
         if (pick < 20)
            send_word(MODE_ALLOC, 7'($urandom()), rand64(), $urandom(), clock_us);
         else if (pick < 55)
            send_word(MODE_ARM, pick < 50 ? pick_live_slot() : 7'($urandom()), ivl,
                      $urandom(), clock_us);
         else if (pick < 67)
            send_word(MODE_RELEASE, pick < 64 ? pick_live_slot() : 7'($urandom()),
                      rand64(), $urandom(), clock_us);
         else
            send_word(MODE_TICK, 7'($urandom()), rand64(), $urandom(), clock_us);
      end
      quiet = 1'b0;
   endtask

   // Hold the output off for a long stretch while commands keep coming
   task automatic test_backpressure();
      long_hold = 400;
      quiet = 1'b1;
      for (int n = 0; n < 30; n++)
         send_word(MODE_TICK, 7'd0, 64'd0, 32'd0, clock_us + n);
      quiet = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) free_slots.push_back(7'(NUM_SLOTS - 1 - i));
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_exhaust();
      test_random(400);
      test_backpressure();
      test_random(400);
      req_valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue_engine_core.sv
test/tb_sorted_timer_queue_engine_core.sv
